[hw/rtl/assert_macros.svh]
// assertion macros used by feedback_echo_delay_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// when pre holds, post must hold in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/fed_pkg.sv]
// types, constants and register map of the feedback echo delay
package fed_pkg;

  // default sizes
  localparam int unsigned RingDepthDef  = 65536;
  localparam int unsigned SampleBitsDef = 16;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  // register widths
  localparam int unsigned ChanW  = 2;
  localparam int unsigned RingW  = 17;
  localparam int unsigned DelayW = 16;
  localparam int unsigned GainW  = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgChannelCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRingLength   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDelaySamples = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFeedbackGain = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOutputGain   = 3'd4;

  // register reset values
  localparam logic [ChanW-1:0]  ChanRst     = 2'd2;
  localparam logic [RingW-1:0]  RingRst     = 17'd48000;
  localparam logic [DelayW-1:0] DelayRst    = 16'd12000;
  localparam logic [GainW-1:0]  FbGainRst   = 16'd32768;
  localparam logic [GainW-1:0]  OutGainRst  = 16'd32768;
  localparam logic [ChanW-1:0]  ChanSingle  = 2'd1;

  // fixed point
  localparam int unsigned MixShift = 13;
  localparam int unsigned FracBits = 15;

  typedef enum logic [1:0] {
    StIdle,
    StMix,
    StStore,
    StOut
  } fed_state_e;

endpackage

[hw/rtl/fed_round_sat.sv]
// round to nearest (ties up) after a 15 bit right shift, then saturate
module fed_round_sat
  import fed_pkg::*;
#(
  parameter int unsigned IN_W  = 34,
  parameter int unsigned OUT_W = 16
) (
  input  logic signed [IN_W-1:0] acc_i,
  output logic        [OUT_W-1:0] sat_o
);

  localparam int unsigned RW = IN_W + 1 - FracBits;

  localparam logic signed [RW-1:0] SatHi = {{(RW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [RW-1:0] SatLo = {{(RW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic signed [IN_W:0] biased;
  logic signed [IN_W:0] shifted;
  logic signed [RW-1:0] rounded;

  always_comb begin
    biased  = {acc_i[IN_W-1], acc_i} + (IN_W+1)'(1 << (FracBits - 1));
    shifted = biased >>> FracBits;
    rounded = shifted[RW-1:0];
    if (rounded > SatHi) begin
      sat_o = SatHi[OUT_W-1:0];
    end else if (rounded < SatLo) begin
      sat_o = SatLo[OUT_W-1:0];
    end else begin
      sat_o = rounded[OUT_W-1:0];
    end
  end

endmodule

[hw/rtl/fed_delay_mod.sv]
// bit serial remainder of the delay by the ring length in use
module fed_delay_mod
  import fed_pkg::*;
#(
  parameter int unsigned LEN_W = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DelayW-1:0] delay_i,
  input  logic [LEN_W-1:0]  len_i,
  output logic              busy_o,
  output logic [LEN_W-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(DelayW);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W:0]  shifted;
  logic [CntW-1:0] bit_sel;

  always_comb begin
    bit_sel = CntW'(DelayW - 1) - cnt_q;
    shifted = {rem_q, delay_i[bit_sel]};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, len_i}) begin
        rem_d = LEN_W'(shifted - {1'b0, len_i});
      end else begin
        rem_d = shifted[LEN_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DelayW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // restarts after reset so the reset registers get their remainder too
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/feedback_echo_delay_core.sv]
// feedback echo delay: mono fold, delay ring with feedback, output gain
//
//  channel | dir | handshake                  | payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | sample_first, sample_second
//  m_axis  | out | m_axis_tvalid/m_axis_tready | echo_sample
//  cfg     | in  | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// each frame passes in order: ring read, feedback multiply, write back with
// output multiply, round into the output register; the ring read-modify-write
// lets a new frame in only once the last has left. after reset and after every
// register write no frame is taken while the delay remainder is recomputed.
// the ring reads as zero until written (fill count), no clearing pass. a
// stalled output holds the next result in its last stage; no new frame is taken meanwhile.
module feedback_echo_delay_core
  import fed_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RingDepthDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  localparam int unsigned InDW  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OutDW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDW-1:0]     s_axis_tdata,   // sample_first, sample_second
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDW-1:0]    m_axis_tdata,   // echo_sample
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned AW   = $clog2(RING_DEPTH);
  localparam int unsigned LW   = (AW + 1 > RingW) ? AW + 1 : RingW;
  localparam int unsigned MixW = SB + 2;
  localparam int unsigned AccW = SB + 18;
  localparam int unsigned PW   = SB + 17;

  // configuration registers
  logic [ChanW-1:0]  chan_q;
  logic [RingW-1:0]  ring_q;
  logic [DelayW-1:0] delay_q;
  logic [GainW-1:0]  fb_gain_q;
  logic [GainW-1:0]  out_gain_q;
  logic              cfg_wr;

  fed_state_e state_q, state_d;

  logic [AW-1:0]   wp_q, wp_d;
  logic [AW-1:0]   wp_cur_q;
  logic [AW:0]     fill_q, fill_d;
  logic [LW-1:0]   len;
  logic [LW-1:0]   ring_ext;
  logic [LW-1:0]   dm;
  logic            mod_busy;
  logic [AW-1:0]   wp_eff;
  logic [LW-1:0]   wp_ext;
  logic [LW-1:0]   rd_ext;
  logic [AW-1:0]   rd_addr;
  logic            in_acc;

  logic signed [SB-1:0]   x0, x1;
  logic signed [MixW-1:0] x0_ext, x1_ext, mix;
  logic signed [MixW-1:0] mix_q;

  logic [SB-1:0]          mem [RING_DEPTH];
  logic [SB-1:0]          rd_data_q;
  logic                   rd_hit_q;
  logic signed [SB-1:0]   echo;
  logic signed [PW-1:0]   fb_prod;
  logic signed [AccW-1:0] acc_d, acc_q;
  logic [SB-1:0]          stored;
  logic signed [PW-1:0]   out_prod_d, out_prod_q;
  logic signed [AccW-1:0] out_prod_ext;
  logic [SB-1:0]          out_sat;
  logic                   wr_en;
  logic [AW:0]            wr_next;
  logic                   out_load;
  logic                   out_valid_q;
  logic [SB-1:0]          out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q     <= ChanRst;
      ring_q     <= RingRst;
      delay_q    <= DelayRst;
      fb_gain_q  <= FbGainRst;
      out_gain_q <= OutGainRst;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CfgChannelCount: chan_q     <= cfg_data_i[ChanW-1:0];
        CfgRingLength:   ring_q     <= cfg_data_i[RingW-1:0];
        CfgDelaySamples: delay_q    <= cfg_data_i[DelayW-1:0];
        CfgFeedbackGain: fb_gain_q  <= cfg_data_i[GainW-1:0];
        CfgOutputGain:   out_gain_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // ring length in use, clamped to [2, RING_DEPTH]
  always_comb begin
    ring_ext = LW'(ring_q);
    if (ring_ext < LW'(2)) begin
      len = LW'(2);
    end else if (ring_ext > LW'(RING_DEPTH)) begin
      len = LW'(RING_DEPTH);
    end else begin
      len = ring_ext;
    end
  end

  fed_delay_mod #(
    .LEN_W (LW)
  ) u_delay_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_wr),
    .delay_i (delay_q),
    .len_i   (len),
    .busy_o  (mod_busy),
    .rem_o   (dm)
  );

  // read index: write pointer minus delay, wrapped once
  always_comb begin
    wp_eff = (LW'(wp_q) >= len) ? '0 : wp_q;
    wp_ext = LW'(wp_eff);
    if (wp_ext >= dm) begin
      rd_ext = wp_ext - dm;
    end else begin
      rd_ext = wp_ext + len - dm;
    end
    rd_addr = rd_ext[AW-1:0];
  end

  assign s_axis_tready = (state_q == StIdle) && !mod_busy;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // mono fold in quarter lsb units
  always_comb begin
    x0     = s_axis_tdata[SB-1:0];
    x1     = s_axis_tdata[2*SB-1:SB];
    x0_ext = {{2{x0[SB-1]}}, x0};
    x1_ext = {{2{x1[SB-1]}}, x1};
    if (chan_q == ChanSingle) begin
      mix = x0_ext <<< 1;
    end else begin
      mix = x0_ext + (x1_ext <<< 1);
    end
  end

  // feedback path
  always_comb begin
    echo    = rd_hit_q ? rd_data_q : '0;
    fb_prod = echo * $signed({1'b0, fb_gain_q});
    acc_d   = {{3{mix_q[MixW-1]}}, mix_q, {MixShift{1'b0}}} + {fb_prod[PW-1], fb_prod};
  end

  fed_round_sat #(
    .IN_W  (AccW),
    .OUT_W (SB)
  ) u_round_store (
    .acc_i (acc_q),
    .sat_o (stored)
  );

  assign out_prod_d   = $signed(stored) * $signed({1'b0, out_gain_q});
  assign out_prod_ext = {out_prod_q[PW-1], out_prod_q};

  fed_round_sat #(
    .IN_W  (AccW),
    .OUT_W (SB)
  ) u_round_out (
    .acc_i (out_prod_ext),
    .sat_o (out_sat)
  );

  assign wr_en   = (state_q == StStore);
  assign wr_next = {1'b0, wp_cur_q} + 1'b1;

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    fill_d   = fill_q;
    out_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StMix;
        end
      end
      StMix: begin
        state_d = StStore;
      end
      StStore: begin
        state_d = StOut;
        if (wr_next > fill_q) begin
          fill_d = wr_next;
        end
        if (LW'(wr_next) >= len) begin
          wp_d = '0;
        end else begin
          wp_d = wr_next[AW-1:0];
        end
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mix_q    <= mix;
      wp_cur_q <= wp_eff;
      rd_hit_q <= {1'b0, rd_addr} < fill_q;
    end
    if (state_q == StMix) begin
      acc_q <= acc_d;
    end
    if (state_q == StStore) begin
      out_prod_q <= out_prod_d;
    end
    if (out_load) begin
      out_q <= out_sat;
    end
  end

  // delay ring
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_cur_q] <= stored;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDW'(out_q);

  `ASSERT_NEXT(a_wp_in_ring, clk_i, rst_ni, state_q == StStore, LW'(wp_q) < len,
               "write pointer beyond ring after store")
  `ASSERT_AT(a_rem_below_len, clk_i, rst_ni, !mod_busy |-> dm < len,
             "delay remainder not below ring length")
  `ASSERT_AT(a_out_from_last_stage, clk_i, rst_ni,
             $rose(m_axis_tvalid) |-> $past(state_q) == StOut,
             "result shown without passing the output stage")
  `ASSERT_NEXT(a_fill_grows, clk_i, rst_ni, 1'b1, fill_q >= $past(fill_q),
               "fill count went down")

endmodule
